[sv/imu_pkg.sv]
`timescale 1ns / 1ps
package imu_pkg;

  typedef struct packed {
    logic               func;
    logic        [31:0] time_stamp;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } entry_t;

  typedef struct packed {
    logic [1:0] ia;
    logic [1:0] ib;
    logic [3:0] t0;
    logic       n0;
    logic [3:0] t1;
    logic       n1;
  } mat_term_t;

  localparam logic        [15:0] QUAT_NEG      = 16'h3950;
  localparam logic signed [34:0] MAT_ONE       = 35'sd268435456;
  localparam logic signed [15:0] Q14_ONE       = 16'sd16384;
  localparam logic        [30:0] THRESH_RESET  = 31'd3277;

  localparam logic [5:0] STEP_QUAT_END = 6'd16;
  localparam logic [5:0] STEP_DTSQ     = 6'd16;
  localparam logic [5:0] STEP_VEL      = 6'd17;
  localparam logic [5:0] STEP_ACC      = 6'd20;
  localparam logic [5:0] STEP_MAT      = 6'd23;
  localparam logic [5:0] STEP_HALF     = 6'd32;
  localparam logic [5:0] STEP_LAST_MUL = 6'd37;
  localparam logic [5:0] STEP_UPDATE   = 6'd39;

  function automatic mat_term_t mat_term(input logic [3:0] j);
    mat_term_t r;
    case (j)
      4'd0:    r = '{2'd1, 2'd2, 4'd1, 1'b0, 4'd3, 1'b0};
      4'd1:    r = '{2'd0, 2'd3, 4'd1, 1'b1, 4'd3, 1'b0};
      4'd2:    r = '{2'd1, 2'd3, 4'd2, 1'b0, 4'd6, 1'b0};
      4'd3:    r = '{2'd0, 2'd2, 4'd2, 1'b0, 4'd6, 1'b1};
      4'd4:    r = '{2'd2, 2'd3, 4'd5, 1'b0, 4'd7, 1'b0};
      4'd5:    r = '{2'd0, 2'd1, 4'd5, 1'b1, 4'd7, 1'b0};
      4'd6:    r = '{2'd1, 2'd1, 4'd4, 1'b1, 4'd8, 1'b1};
      4'd7:    r = '{2'd2, 2'd2, 4'd0, 1'b1, 4'd8, 1'b1};
      4'd8:    r = '{2'd3, 2'd3, 4'd0, 1'b1, 4'd4, 1'b1};
      default: r = '{2'd0, 2'd0, 4'd0, 1'b0, 4'd0, 1'b0};
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] round_q14(input logic signed [34:0] x);
    logic signed [34:0] s;
    logic signed [20:0] f;
    s = x + 35'sd8192;
    f = s[34:14];
    if (f > 21'sd32767) return 16'sd32767;
    if (f < -21'sd32768) return -16'sd32768;
    return f[15:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  function automatic logic [32:0] clamp32(input logic signed [56:0] x);
    if (x > 57'sd2147483647) return {1'b1, 32'h7fffffff};
    if (x < -57'sd2147483648) return {1'b1, 32'h80000000};
    return {1'b0, x[31:0]};
  endfunction

endpackage

[sv/imu_if.sv]
`timescale 1ns / 1ps
interface imu_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic        [31:0] time_stamp;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  logic signed [31:0] acc_z;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source (output valid, func, time_stamp, acc_x, acc_y, acc_z,
                  quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, func, time_stamp, acc_x, acc_y, acc_z,
                quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface imu_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  axis;
  logic signed [31:0] position;
  logic signed [31:0] velocity;
  logic signed [15:0] rot_col0;
  logic signed [15:0] rot_col1;
  logic signed [15:0] rot_col2;
  logic               last;
  logic               motion_reached;
  logic               saturated;

  modport source (output valid, axis, position, velocity, rot_col0, rot_col1, rot_col2,
                  last, motion_reached, saturated, input ready);
  modport sink (input valid, axis, position, velocity, rot_col0, rot_col1, rot_col2,
                last, motion_reached, saturated, output ready);
endinterface

[sv/imu_preintegration_step.sv]
// keyframe or first sample: input queue, IDLE, EMIT, then the row register
// integrating sample: input queue, IDLE, RUN steps 0 to 39, EMIT, row register
// a sample is taken only in IDLE; three rows at one per cycle unless stalled; the
//   38 products of a sample share one 33x33 multiplier, one product per cycle
// reset: synchronous, clears state, identity orientation, threshold 3277
`timescale 1ns / 1ps
module imu_preintegration_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata,
  imu_in_if.sink      samples,
  imu_out_if.source   rows
);
  import imu_pkg::*;

  logic   q_valid;
  logic   q_ready;
  entry_t q_entry;

  imu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_entry (q_entry)
  );

  imu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_entry   (q_entry),
    .rows      (rows)
  );

endmodule

[sv/imu_front.sv]
`timescale 1ns / 1ps
module imu_front (
  input  logic           clk,
  input  logic           rst,
  imu_in_if.sink         samples,
  output logic           q_valid,
  input  logic           q_ready,
  output imu_pkg::entry_t q_entry
);
  import imu_pkg::*;

  entry_t     mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign samples.ready = (cnt != 2'd2);
  assign push          = samples.valid && samples.ready;
  assign q_valid       = (cnt != 2'd0);
  assign pop           = q_valid && q_ready;
  assign q_entry       = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= '{samples.func, samples.time_stamp, samples.acc_x, samples.acc_y,
                   samples.acc_z, samples.quat_w, samples.quat_x, samples.quat_y,
                   samples.quat_z};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

[sv/imu_back.sv]
`timescale 1ns / 1ps
module imu_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [30:0]     cfg_wdata,
  input  logic            q_valid,
  output logic            q_ready,
  input  imu_pkg::entry_t q_entry,
  imu_out_if.source       rows
);
  import imu_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state;
  logic [5:0]         step;
  logic [1:0]         row;
  logic [30:0]        motion_threshold;
  logic               have_first;
  logic               sat_seen;
  logic               kf;
  logic [31:0]        prev_time;
  logic [31:0]        cur_time;
  logic [31:0]        dt;
  logic signed [15:0] prev_q [4];
  logic signed [15:0] cur_q  [4];
  logic signed [31:0] acc_in [3];
  logic signed [31:0] pos    [3];
  logic signed [31:0] vel    [3];
  logic signed [15:0] rot    [9];
  logic signed [33:0] qacc   [4];
  logic signed [34:0] macc   [9];
  logic signed [15:0] rq     [4];
  logic [63:0]        dd;
  logic signed [44:0] tv     [3];
  logic signed [44:0] ta     [3];
  logic [95:0]        hacc   [3];
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic [5:0]         mul_op;
  logic               mul_live;
  mat_term_t          mt_issue;
  mat_term_t          mt_acc;
  logic [1:0]         iv;
  logic [1:0]         ia;
  logic [1:0]         ih;
  logic [1:0]         ov;
  logic [1:0]         oa;
  logic [1:0]         oh;
  logic signed [34:0] two_p;
  logic signed [44:0] mag_sh;
  logic [32:0]        pclamp [3];
  logic [32:0]        vclamp [3];
  logic               any_hit;
  logic               motion;
  logic               load;
  logic [3:0]         rbase;

  assign q_ready = (state == ST_IDLE);

  always_comb begin
    for (int k = 0; k < 4; k++) rq[k] = round_q14({qacc[k][33], qacc[k]});
  end

  // operand select for the shared multiplier
  always_comb begin
    mt_issue = mat_term(4'(step - STEP_MAT));
    iv       = 2'(step - STEP_VEL);
    ia       = 2'(step - STEP_ACC);
    ih       = 2'((step - STEP_HALF) >> 1);
    mul_a    = '0;
    mul_b    = '0;
    if (step < STEP_QUAT_END) begin
      mul_a = {{17{cur_q[step[1:0]][15]}}, cur_q[step[1:0]]};
      mul_b = {{17{prev_q[step[1:0] ^ step[3:2]][15]}}, prev_q[step[1:0] ^ step[3:2]]};
    end else if (step == STEP_DTSQ) begin
      mul_a = {1'b0, dt};
      mul_b = {1'b0, dt};
    end else if (step < STEP_ACC) begin
      mul_a = {1'b0, mag32(vel[iv])};
      mul_b = {1'b0, dt};
    end else if (step < STEP_MAT) begin
      mul_a = {1'b0, mag32(acc_in[ia])};
      mul_b = {1'b0, dt};
    end else if (step < STEP_HALF) begin
      mul_a = {{17{rq[mt_issue.ia][15]}}, rq[mt_issue.ia]};
      mul_b = {{17{rq[mt_issue.ib][15]}}, rq[mt_issue.ib]};
    end else if (step <= STEP_LAST_MUL) begin
      mul_a = {1'b0, mag32(acc_in[ih])};
      mul_b = step[0] ? {1'b0, dd[31:0]} : {1'b0, dd[63:32]};
    end
  end

  always_comb begin
    mt_acc = mat_term(4'(mul_op - STEP_MAT));
    ov     = 2'(mul_op - STEP_VEL);
    oa     = 2'(mul_op - STEP_ACC);
    oh     = 2'((mul_op - STEP_HALF) >> 1);
    two_p  = {mul_p[33:0], 1'b0};
    mag_sh = {1'b0, mul_p[63:20]};
  end

  // position and velocity update, all three axes at once
  always_comb begin
    logic signed [56:0] hs;
    logic signed [56:0] psum;
    logic signed [56:0] vsum;
    any_hit = 1'b0;
    for (int k = 0; k < 3; k++) begin
      hs   = {2'b00, hacc[k][95:41]};
      psum = {{25{pos[k][31]}}, pos[k]} + {{12{tv[k][44]}}, tv[k]}
             + (acc_in[k][31] ? -hs : hs);
      vsum = {{25{vel[k][31]}}, vel[k]} + {{12{ta[k][44]}}, ta[k]};
      pclamp[k] = clamp32(psum);
      vclamp[k] = clamp32(vsum);
      any_hit   = any_hit | pclamp[k][32] | vclamp[k][32];
    end
  end

  always_comb begin
    motion = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (pos[k] > $signed({1'b0, motion_threshold})) motion = 1'b1;
    end
  end

  assign load  = (state == ST_EMIT) && (!rows.valid || rows.ready);
  assign rbase = 4'({row, 1'b0}) + 4'(row);

  always_ff @(posedge clk) begin
    mul_p  <= mul_a * mul_b;
    mul_op <= step;
    if (state == ST_IDLE && q_valid) begin
      cur_time  <= q_entry.time_stamp;
      cur_q[0]  <= q_entry.quat_w;
      cur_q[1]  <= q_entry.quat_x;
      cur_q[2]  <= q_entry.quat_y;
      cur_q[3]  <= q_entry.quat_z;
      acc_in[0] <= q_entry.acc_x;
      acc_in[1] <= q_entry.acc_y;
      acc_in[2] <= q_entry.acc_z;
      kf        <= q_entry.func;
      dt        <= q_entry.time_stamp - prev_time;
      for (int k = 0; k < 4; k++) qacc[k] <= '0;
      for (int k = 0; k < 9; k++) begin
        macc[k] <= (k == 0 || k == 4 || k == 8) ? MAT_ONE : '0;
      end
    end
    if (mul_live) begin
      if (mul_op < STEP_QUAT_END) begin
        qacc[mul_op[3:2]] <= QUAT_NEG[mul_op[3:0]] ? qacc[mul_op[3:2]] - mul_p[33:0]
                                                    : qacc[mul_op[3:2]] + mul_p[33:0];
      end else if (mul_op == STEP_DTSQ) begin
        dd <= mul_p[63:0];
      end else if (mul_op < STEP_ACC) begin
        tv[ov] <= vel[ov][31] ? -mag_sh : mag_sh;
      end else if (mul_op < STEP_MAT) begin
        ta[oa] <= acc_in[oa][31] ? -mag_sh : mag_sh;
      end else if (mul_op < STEP_HALF) begin
        macc[mt_acc.t0] <= mt_acc.n0 ? macc[mt_acc.t0] - two_p : macc[mt_acc.t0] + two_p;
        macc[mt_acc.t1] <= mt_acc.n1 ? macc[mt_acc.t1] - two_p : macc[mt_acc.t1] + two_p;
      end else begin
        hacc[oh] <= mul_op[0] ? hacc[oh] + {32'd0, mul_p[63:0]} : {mul_p[63:0], 32'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      step             <= '0;
      row              <= '0;
      mul_live         <= 1'b0;
      motion_threshold <= THRESH_RESET;
      have_first       <= 1'b0;
      sat_seen         <= 1'b0;
      prev_time        <= '0;
      prev_q[0]        <= Q14_ONE;
      for (int k = 1; k < 4; k++) prev_q[k] <= '0;
      for (int k = 0; k < 3; k++) begin
        pos[k] <= '0;
        vel[k] <= '0;
      end
      for (int k = 0; k < 9; k++) rot[k] <= '0;
      rows.valid       <= 1'b0;
    end else begin
      if (cfg_we) motion_threshold <= cfg_wdata;
      mul_live <= (state == ST_RUN) && (step <= STEP_LAST_MUL);
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            row  <= '0;
            step <= '0;
            if (q_entry.func) begin
              state <= ST_EMIT;
            end else if (!have_first) begin
              have_first <= 1'b1;
              prev_time  <= q_entry.time_stamp;
              prev_q[0]  <= q_entry.quat_w;
              prev_q[1]  <= q_entry.quat_x;
              prev_q[2]  <= q_entry.quat_y;
              prev_q[3]  <= q_entry.quat_z;
              state      <= ST_EMIT;
            end else begin
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          step <= step + 6'd1;
          if (step == STEP_UPDATE) begin
            for (int k = 0; k < 3; k++) begin
              pos[k] <= pclamp[k][31:0];
              vel[k] <= vclamp[k][31:0];
            end
            for (int k = 0; k < 9; k++) rot[k] <= round_q14(macc[k]);
            for (int k = 0; k < 4; k++) prev_q[k] <= cur_q[k];
            prev_time <= cur_time;
            sat_seen  <= sat_seen | any_hit;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load) begin
            row <= row + 2'd1;
            if (row == 2'd2) begin
              state <= ST_IDLE;
              if (kf) begin
                for (int k = 0; k < 3; k++) pos[k] <= '0;
                for (int k = 0; k < 9; k++) rot[k] <= '0;
                sat_seen <= 1'b0;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (load) rows.valid <= 1'b1;
      else if (rows.ready) rows.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rows.axis           <= row;
      rows.position       <= pos[row];
      rows.velocity       <= vel[row];
      rows.rot_col0       <= rot[rbase];
      rows.rot_col1       <= rot[rbase + 4'd1];
      rows.rot_col2       <= rot[rbase + 4'd2];
      rows.last           <= (row == 2'd2);
      rows.motion_reached <= motion;
      rows.saturated      <= sat_seen;
    end
  end

endmodule

[sv/imu_chk.sv]
`timescale 1ns / 1ps
module imu_chk (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         axis,
  input logic signed [31:0] position,
  input logic               last
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("row valid after reset");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (axis == 2'd2)) && (axis != 2'd3))
    else $error("last flag does not match axis");

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && axis == 2'd0 |=> out_valid && axis == 2'd1)
    else $error("row after axis 0 missing");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(axis) && $stable(position))
    else $error("stalled row changed");

endmodule

bind imu_preintegration_step imu_chk u_imu_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (rows.valid),
  .out_ready (rows.ready),
  .axis      (rows.axis),
  .position  (rows.position),
  .last      (rows.last)
);
